// ===== sv/pixel_white_balance_luma_keep_unit_defines.svh =====
// Assertion macros shared by the white balance RTL.
// Included by pwb_div.sv and pixel_white_balance_luma_keep_unit.sv; no other dependencies.
`ifndef PIXEL_WHITE_BALANCE_LUMA_KEEP_UNIT_DEFINES_SVH
`define PIXEL_WHITE_BALANCE_LUMA_KEEP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while the given reset is low
`define PWB_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pwb assertion failed");
// Same, on the module's own i_clk / i_rst_n
`define PWB_ASSERT(lbl, prop) `PWB_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define PWB_ASSERT_CLK(lbl, clk, rst_n, prop)
`define PWB_ASSERT(lbl, prop)
`endif

`endif

// ===== sv/pwb_pkg.sv =====
// Shared constants and types for the luminance-keeping white balance block.
// No dependencies; used by the top level pixel_white_balance_luma_keep_unit.sv.
package pwb_pkg;

    // Rec.709 luma weights, Q0.16, summing to 1.0
    localparam int unsigned WEIGHT_BITS = 16;
    localparam logic [WEIGHT_BITS-1:0] W_RED   = 16'd13933;
    localparam logic [WEIGHT_BITS-1:0] W_GREEN = 16'd46871;
    localparam logic [WEIGHT_BITS-1:0] W_BLUE  = 16'd4732;

    // Gains are unsigned Q3.13
    localparam int unsigned GAIN_BITS = 16;
    localparam int unsigned GAIN_FRAC = 13;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd8192;

    // Luma ratio, Q.16 in a 32-bit word (stays below 2^31 by construction)
    localparam int unsigned SCALE_BITS = 32;
    localparam int unsigned SCALE_FRAC = 16;

    // Register map
    localparam int unsigned CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BYPASS     = 2'd0,
        CFG_RED_GAIN   = 2'd1,
        CFG_GREEN_GAIN = 2'd2,
        CFG_BLUE_GAIN  = 2'd3
    } t_cfg_idx;

endpackage

// ===== sv/pixel_white_balance_luma_keep_unit.sv =====
// Top level: luminance-keeping white balance, one RGB pixel per transaction.
// Depends on pwb_pkg, pwb_div and pixel_white_balance_luma_keep_unit_defines.svh.
//
//   port group  dir  payload (low bits first)            transaction when
//   s_axis_*    in   red_in, green_in, blue_in           tvalid && tready
//   m_axis_*    out  red_out, green_out, blue_out        tvalid && tready
//   i_cfg_*     in   index 0 bypass, 1..3 rgb gains      i_cfg_we high
//
// One pixel per clock sustained while the output is not stalled: four stages for
// gains and both lumas, 32 divider stages for the luma ratio, then scale and saturate.
// Synchronous reset empties every stage and restores bypass with unity gains.
// Each stage holds while its successor is full, so bubbles close up and a
// stalled output keeps the input open until the whole pipe is occupied.
`include "pixel_white_balance_luma_keep_unit_defines.svh"

module pixel_white_balance_luma_keep_unit #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pwb_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [pwb_pkg::GAIN_BITS-1:0]          i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // red_in, green_in, blue_in, zero pad
    input  logic [((3*PIXEL_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // red_out, green_out, blue_out, zero pad
    output logic [((3*PIXEL_BITS+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int unsigned P     = PIXEL_BITS;
    localparam int unsigned TDW   = ((3*P+7)/8)*8;
    localparam int unsigned GPW   = P + pwb_pkg::GAIN_BITS;           // pixel x gain
    localparam int unsigned GW    = GPW - pwb_pkg::GAIN_FRAC;          // gained pixel
    localparam int unsigned OLW   = P + pwb_pkg::WEIGHT_BITS;          // old luma
    localparam int unsigned NLW   = GW + pwb_pkg::WEIGHT_BITS;         // new luma
    localparam int unsigned NUMW  = OLW + pwb_pkg::SCALE_FRAC + 1;     // ratio numerator
    localparam int unsigned QW    = pwb_pkg::SCALE_BITS;
    localparam int unsigned MW    = GW + QW;                           // gained x scale
    localparam int unsigned RW    = MW - pwb_pkg::SCALE_FRAC;
    localparam int unsigned CTXW  = 1 + 3*GW;
    localparam logic [GPW-1:0] ROUND_G = GPW'(1) << (pwb_pkg::GAIN_FRAC - 1);
    localparam logic [MW-1:0]  ROUND_S = MW'(1) << (pwb_pkg::SCALE_FRAC - 1);
    localparam logic [QW-1:0]  SCALE_ONE = QW'(1) << pwb_pkg::SCALE_FRAC;
    localparam logic [NLW-1:0] LUMA_MIN = NLW'((64'd1 << (PIXEL_BITS + 15)) / 64'd10000);

    // round, drop the scale fraction and saturate at the pixel top
    function automatic logic [P-1:0] f_round_clip(input logic [MW-1:0] prod);
        logic [MW-1:0] sum;
        logic [RW-1:0] val;
        sum = prod + ROUND_S;
        val = RW'(sum >> pwb_pkg::SCALE_FRAC);
        return (|val[RW-1:P]) ? {P{1'b1}} : val[P-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    logic                          r_bypass;
    logic [pwb_pkg::GAIN_BITS-1:0] r_red_gain;
    logic [pwb_pkg::GAIN_BITS-1:0] r_green_gain;
    logic [pwb_pkg::GAIN_BITS-1:0] r_blue_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass     <= 1'b1;
            r_red_gain   <= pwb_pkg::GAIN_UNITY;
            r_green_gain <= pwb_pkg::GAIN_UNITY;
            r_blue_gain  <= pwb_pkg::GAIN_UNITY;
        end else if (i_cfg_we) begin
            unique case (pwb_pkg::t_cfg_idx'(i_cfg_idx))
                pwb_pkg::CFG_BYPASS:     r_bypass     <= i_cfg_wdata[0];
                pwb_pkg::CFG_RED_GAIN:   r_red_gain   <= i_cfg_wdata;
                pwb_pkg::CFG_GREEN_GAIN: r_green_gain <= i_cfg_wdata;
                pwb_pkg::CFG_BLUE_GAIN:  r_blue_gain  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage advance chain
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_out_v;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld5, w_ld6;
    logic w_div_in_ready, w_div_v;
    logic [QW-1:0]   w_div_q;
    logic [CTXW-1:0] w_div_ctx;

    assign w_ld6 = !r_out_v || m_axis_tready;
    assign w_ld5 = !r_s5_v || w_ld6;
    assign w_ld4 = !r_s4_v || w_div_in_ready;
    assign w_ld3 = !r_s3_v || w_ld4;
    assign w_ld2 = !r_s2_v || w_ld3;
    assign w_ld1 = !r_s1_v || w_ld2;
    assign s_axis_tready = w_ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_ld1) r_s1_v  <= s_axis_tvalid;
            if (w_ld2) r_s2_v  <= r_s1_v;
            if (w_ld3) r_s3_v  <= r_s2_v;
            if (w_ld4) r_s4_v  <= r_s3_v;
            if (w_ld5) r_s5_v  <= w_div_v;
            if (w_ld6) r_out_v <= r_s5_v;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: gain products and old luma products
    logic [P-1:0]   w_in_r, w_in_g, w_in_b;
    logic [GPW-1:0] n_s1_gr, n_s1_gg, n_s1_gb;
    logic [OLW-1:0] n_s1_lr, n_s1_lg, n_s1_lb;
    logic [GPW-1:0] r_s1_gr, r_s1_gg, r_s1_gb;
    logic [OLW-1:0] r_s1_lr, r_s1_lg, r_s1_lb;
    logic [P-1:0]   r_s1_in_r, r_s1_in_g, r_s1_in_b;
    logic           r_s1_byp;

    assign w_in_r = s_axis_tdata[P-1:0];
    assign w_in_g = s_axis_tdata[2*P-1:P];
    assign w_in_b = s_axis_tdata[3*P-1:2*P];

    always_comb begin
        n_s1_gr = GPW'(w_in_r) * GPW'(r_red_gain);
        n_s1_gg = GPW'(w_in_g) * GPW'(r_green_gain);
        n_s1_gb = GPW'(w_in_b) * GPW'(r_blue_gain);
        n_s1_lr = OLW'(w_in_r) * OLW'(pwb_pkg::W_RED);
        n_s1_lg = OLW'(w_in_g) * OLW'(pwb_pkg::W_GREEN);
        n_s1_lb = OLW'(w_in_b) * OLW'(pwb_pkg::W_BLUE);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1_gr   <= n_s1_gr;
            r_s1_gg   <= n_s1_gg;
            r_s1_gb   <= n_s1_gb;
            r_s1_lr   <= n_s1_lr;
            r_s1_lg   <= n_s1_lg;
            r_s1_lb   <= n_s1_lb;
            r_s1_in_r <= w_in_r;
            r_s1_in_g <= w_in_g;
            r_s1_in_b <= w_in_b;
            r_s1_byp  <= r_bypass;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: round gained channels, sum old luma; bypass takes the input
    logic [GW-1:0]  n_s2_gr, n_s2_gg, n_s2_gb;
    logic [OLW-1:0] n_s2_old;
    logic [GW-1:0]  r_s2_gr, r_s2_gg, r_s2_gb;
    logic [OLW-1:0] r_s2_old;
    logic           r_s2_byp;

    always_comb begin
        n_s2_gr  = r_s1_byp ? GW'(r_s1_in_r)
                            : GW'((r_s1_gr + ROUND_G) >> pwb_pkg::GAIN_FRAC);
        n_s2_gg  = r_s1_byp ? GW'(r_s1_in_g)
                            : GW'((r_s1_gg + ROUND_G) >> pwb_pkg::GAIN_FRAC);
        n_s2_gb  = r_s1_byp ? GW'(r_s1_in_b)
                            : GW'((r_s1_gb + ROUND_G) >> pwb_pkg::GAIN_FRAC);
        n_s2_old = r_s1_lr + r_s1_lg + r_s1_lb;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2_gr  <= n_s2_gr;
            r_s2_gg  <= n_s2_gg;
            r_s2_gb  <= n_s2_gb;
            r_s2_old <= n_s2_old;
            r_s2_byp <= r_s1_byp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: new luma products
    logic [NLW-1:0] n_s3_nr, n_s3_ng, n_s3_nb;
    logic [NLW-1:0] r_s3_nr, r_s3_ng, r_s3_nb;
    logic [GW-1:0]  r_s3_gr, r_s3_gg, r_s3_gb;
    logic [OLW-1:0] r_s3_old;
    logic           r_s3_byp;

    always_comb begin
        n_s3_nr = NLW'(r_s2_gr) * NLW'(pwb_pkg::W_RED);
        n_s3_ng = NLW'(r_s2_gg) * NLW'(pwb_pkg::W_GREEN);
        n_s3_nb = NLW'(r_s2_gb) * NLW'(pwb_pkg::W_BLUE);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_s3_nr  <= n_s3_nr;
            r_s3_ng  <= n_s3_ng;
            r_s3_nb  <= n_s3_nb;
            r_s3_gr  <= r_s2_gr;
            r_s3_gg  <= r_s2_gg;
            r_s3_gb  <= r_s2_gb;
            r_s3_old <= r_s2_old;
            r_s3_byp <= r_s2_byp;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: new luma, dark test, ratio operands (0 / 1 when no rescale)
    logic [NLW-1:0]  w_s4_new;
    logic            n_s4_dark;
    logic [NUMW-1:0] n_s4_num;
    logic [NLW-1:0]  n_s4_den;
    logic [NUMW-1:0] r_s4_num;
    logic [NLW-1:0]  r_s4_den;
    logic [CTXW-1:0] r_s4_ctx;

    always_comb begin
        w_s4_new  = r_s3_nr + r_s3_ng + r_s3_nb;
        n_s4_dark = r_s3_byp || !((w_s4_new > LUMA_MIN) && (NLW'(r_s3_old) > LUMA_MIN));
        n_s4_num  = n_s4_dark ? '0
                    : (NUMW'(r_s3_old) << pwb_pkg::SCALE_FRAC) + NUMW'(w_s4_new >> 1);
        n_s4_den  = n_s4_dark ? NLW'(1) : w_s4_new;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_s4_num <= n_s4_num;
            r_s4_den <= n_s4_den;
            r_s4_ctx <= {n_s4_dark, r_s3_gb, r_s3_gg, r_s3_gr};
        end
    end

    // ---------------------------------------------------------------
    // Luma ratio old/new in Q.16
    pwb_div #(
        .DEN_BITS (NLW),
        .NUM_BITS (NUMW),
        .Q_BITS   (QW),
        .CTX_BITS (CTXW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_s4_v),
        .o_in_ready  (w_div_in_ready),
        .i_num       (r_s4_num),
        .i_den       (r_s4_den),
        .i_ctx       (r_s4_ctx),
        .o_out_valid (w_div_v),
        .i_out_ready (w_ld5),
        .o_quo       (w_div_q),
        .o_ctx       (w_div_ctx)
    );

    // ---------------------------------------------------------------
    // Stage 5: scale each channel; unity scale on dark or bypassed pixels
    logic            w_s5_dark;
    logic [QW-1:0]   w_s5_scale;
    logic [GW-1:0]   w_s5_gr, w_s5_gg, w_s5_gb;
    logic [MW-1:0]   n_s5_pr, n_s5_pg, n_s5_pb;
    logic [MW-1:0]   r_s5_pr, r_s5_pg, r_s5_pb;

    always_comb begin
        w_s5_dark  = w_div_ctx[CTXW-1];
        w_s5_gr    = w_div_ctx[GW-1:0];
        w_s5_gg    = w_div_ctx[2*GW-1:GW];
        w_s5_gb    = w_div_ctx[3*GW-1:2*GW];
        w_s5_scale = w_s5_dark ? SCALE_ONE : w_div_q;
        n_s5_pr    = MW'(w_s5_gr) * MW'(w_s5_scale);
        n_s5_pg    = MW'(w_s5_gg) * MW'(w_s5_scale);
        n_s5_pb    = MW'(w_s5_gb) * MW'(w_s5_scale);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld5) begin
            r_s5_pr <= n_s5_pr;
            r_s5_pg <= n_s5_pg;
            r_s5_pb <= n_s5_pb;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: round, saturate, output register
    logic [P-1:0] r_out_r, r_out_g, r_out_b;

    always_ff @(posedge i_clk) begin
        if (w_ld6) begin
            r_out_r <= f_round_clip(r_s5_pr);
            r_out_g <= f_round_clip(r_s5_pg);
            r_out_b <= f_round_clip(r_s5_pb);
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = TDW'({r_out_b, r_out_g, r_out_r});

    // ---------------------------------------------------------------
    // Checks
    // ratio fits the quotient width: numerator high part below divisor
    `PWB_ASSERT(a_num_fits, r_s4_v |-> (r_s4_num[NUMW-1:QW] < r_s4_den))
    // luma ratio stays below 2^31 whenever it is used
    `PWB_ASSERT(a_scale_range, (w_div_v && !w_div_ctx[CTXW-1]) |-> !w_div_q[QW-1])
    // a finished product reaches the output when the output register frees
    `PWB_ASSERT(a_tail_drains, (r_s5_v && w_ld6) |=> m_axis_tvalid)

endmodule

// ===== sv/pwb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on pixel_white_balance_luma_keep_unit_defines.svh for assertion macros.
`include "pixel_white_balance_luma_keep_unit_defines.svh"

module pwb_div #(
    parameter int unsigned DEN_BITS = 35,
    parameter int unsigned NUM_BITS = 49,
    parameter int unsigned Q_BITS   = 32,
    parameter int unsigned CTX_BITS = 58
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [NUM_BITS-1:0] i_num,      // quotient must fit Q_BITS
    input  logic [DEN_BITS-1:0] i_den,
    input  logic [CTX_BITS-1:0] i_ctx,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [Q_BITS-1:0]   o_quo,
    output logic [CTX_BITS-1:0] o_ctx
);

    logic                r_v   [Q_BITS];
    logic [DEN_BITS-1:0] r_rem [Q_BITS];
    logic [DEN_BITS-1:0] r_den [Q_BITS];
    logic [Q_BITS-1:0]   r_lo  [Q_BITS];   // numerator bits still to use, quotient bits below
    logic [CTX_BITS-1:0] r_ctx [Q_BITS];
    wire                 w_ld  [Q_BITS];
    wire  [Q_BITS-1:0]   w_vbits;

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic                p_v;
        logic [DEN_BITS-1:0] p_rem;
        logic [DEN_BITS-1:0] p_den;
        logic [Q_BITS-1:0]   p_lo;
        logic [CTX_BITS-1:0] p_ctx;
        logic [DEN_BITS:0]   w_sh;
        logic [DEN_BITS:0]   w_diff;
        logic                w_ge;

        // previous stage, or the input port for the first one
        if (k == 0) begin : g_head
            assign p_v   = i_in_valid;
            assign p_rem = DEN_BITS'(i_num[NUM_BITS-1:Q_BITS]);
            assign p_lo  = i_num[Q_BITS-1:0];
            assign p_den = i_den;
            assign p_ctx = i_ctx;
        end else begin : g_body
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_lo  = r_lo[k-1];
            assign p_den = r_den[k-1];
            assign p_ctx = r_ctx[k-1];
        end

        // stage moves when empty or when its successor moves
        if (k == Q_BITS - 1) begin : g_last
            assign w_ld[k] = !r_v[k] || i_out_ready;
        end else begin : g_mid
            assign w_ld[k] = !r_v[k] || w_ld[k+1];
        end

        // shift in one numerator bit, subtract when it fits
        assign w_sh   = {p_rem, p_lo[Q_BITS-1]};
        assign w_ge   = (w_sh >= {1'b0, p_den});
        assign w_diff = w_sh - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_ld[k]) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[k]) begin
                r_rem[k] <= w_ge ? w_diff[DEN_BITS-1:0] : w_sh[DEN_BITS-1:0];
                r_lo[k]  <= {p_lo[Q_BITS-2:0], w_ge};
                r_den[k] <= p_den;
                r_ctx[k] <= p_ctx;
            end
        end

        assign w_vbits[k] = r_v[k];
    end

    assign o_in_ready  = w_ld[0];
    assign o_out_valid = r_v[Q_BITS-1];
    assign o_quo       = r_lo[Q_BITS-1];
    assign o_ctx       = r_ctx[Q_BITS-1];

    // partial remainder always below the divisor, divisor never zero
    for (genvar k = 0; k < Q_BITS; k++) begin : g_chk
        `PWB_ASSERT(a_rem_below_den, r_v[k] |-> (r_rem[k] < r_den[k]))
        `PWB_ASSERT(a_den_nonzero, r_v[k] |-> (r_den[k] != '0))
    end
    // a full pipe with a stalled output takes nothing new
    `PWB_ASSERT(a_full_blocks, ((&w_vbits) && !i_out_ready) |-> !o_in_ready)

endmodule
